FILE: rtl/set_assoc_tlb_lru_defines.svh
// Assertion macros used by the checker file of the TLB.
`ifndef SET_ASSOC_TLB_LRU_DEFINES_SVH
`define SET_ASSOC_TLB_LRU_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define STLB_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stlb check failed");

// Next-cycle implication, sampled on the rising clock and off during reset.
`define STLB_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stlb check failed");

`endif

FILE: rtl/stlb_pkg.sv
// Shared constants and controller/datapath interface types of the TLB.
package stlb_pkg;

   localparam int SET_COUNT  = 16;
   localparam int NUM_WAYS   = 4;
   localparam int ADDR_WIDTH = 32;

   localparam int VADDR_W  = 32;
   localparam int PHYS_W   = 32;
   localparam int CNT_W    = 32;
   localparam int PAGE_W   = 28;
   localparam int TAG_W    = 28;
   localparam int OFFCFG_W = 5;

   localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   // Index bits are floor(log2(SET_COUNT)).
   localparam int IDX_BITS = $clog2(SET_COUNT + 1) - 1;
   localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int AGE_W    = WAY_W;
   localparam int SHIFT_W  = 6;
   localparam int WIDE_W   = ADDR_WIDTH + PAGE_W;

   localparam logic [OFFCFG_W-1:0] OFFSET_RESET = OFFCFG_W'(12);
   localparam logic [OFFCFG_W-1:0] OFFSET_MIN   = OFFCFG_W'(4);
   localparam logic [OFFCFG_W-1:0] OFFSET_MAX   = OFFCFG_W'(16);

   localparam logic MODE_TRANSLATE  = 1'b0;
   localparam logic MODE_INVALIDATE = 1'b1;

   typedef struct packed {
      logic capture;     // latch the request and read its set
      logic inv_read;    // read the row under the sweep counter
      logic inv_clear;   // clear matching entries of that row, advance sweep
      logic xlate_done;  // finish a translation and load the result
      logic inv_done;    // load the result of an invalidation
   } stlb_cmd_type;

   typedef struct packed {
      logic walk_last;
   } stlb_status_type;

endpackage

FILE: rtl/stlb_ctrl.sv
// Controller state machine of the TLB: handshakes and datapath sequencing.
module stlb_ctrl import stlb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_mode,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output stlb_cmd_type    cmd,
   input  stlb_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XLATE,
      ST_INV_READ,
      ST_INV_CLEAR,
      ST_INV_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result if it is empty or is being
   // transferred out in this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_mode == MODE_INVALIDATE) ? ST_INV_READ : ST_XLATE;
            end
         end
         ST_XLATE: begin
            if (out_free) begin
               cmd.xlate_done = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_INV_READ: begin
            cmd.inv_read = 1'b1;
            state_in     = ST_INV_CLEAR;
         end
         ST_INV_CLEAR: begin
            cmd.inv_clear = 1'b1;
            state_in      = status.walk_last ? ST_INV_DONE : ST_INV_READ;
         end
         ST_INV_DONE: begin
            if (out_free) begin
               cmd.inv_done = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/stlb_dp.sv
// Datapath of the TLB: entry memories, valid and age flops, lookup, counters.
module stlb_dp import stlb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  stlb_cmd_type        cmd,
   output stlb_status_type     status,
   input  logic                csr_wr_en,
   input  logic [OFFCFG_W-1:0] csr_wr_data,
   input  logic [VADDR_W-1:0]  req_virt_addr,
   input  logic [PAGE_W-1:0]   req_walk_page,
   input  logic [PAGE_W-1:0]   req_target_page,
   output logic [PHYS_W-1:0]   rsp_phys_addr,
   output logic                rsp_hit,
   output logic [CNT_W-1:0]    rsp_access_total,
   output logic [CNT_W-1:0]    rsp_hit_total
);

   localparam logic [ADDR_WIDTH-1:0] IDX_MASK = ADDR_WIDTH'((1 << IDX_BITS) - 1);

   logic [OFFCFG_W-1:0] offset_bits_ff;
   logic [OFFCFG_W-1:0] eff_off;

   logic [ADDR_WIDTH-1:0] vaddr;
   logic [SHIFT_W-1:0]    tag_shift;
   logic [ADDR_WIDTH-1:0] req_offset;
   logic [SET_W-1:0]      req_set;
   logic [TAG_W-1:0]      req_tag;

   logic [SET_W-1:0]      set_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [ADDR_WIDTH-1:0] offset_ff;
   logic [PAGE_W-1:0]     walk_page_ff;
   logic [PAGE_W-1:0]     target_page_ff;
   logic [SET_W-1:0]      walk_cnt_ff;

   logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_mem  [SET_COUNT];
   logic [NUM_WAYS-1:0][PAGE_W-1:0] page_mem [SET_COUNT];
   logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_row_ff, tag_row_in;
   logic [NUM_WAYS-1:0][PAGE_W-1:0] page_row_ff, page_row_in;
   logic [SET_W-1:0]                rd_addr;
   logic                            rd_en;
   logic                            wr_en;

   logic [SET_COUNT-1:0][NUM_WAYS-1:0]            valid_ff, valid_in;
   logic [SET_COUNT-1:0][NUM_WAYS-1:0][AGE_W-1:0] age_ff, age_in;

   logic [NUM_WAYS-1:0]            cur_valid;
   logic [NUM_WAYS-1:0][AGE_W-1:0] cur_age;
   logic                           hit_any;
   logic [WAY_W-1:0]               hit_way;
   logic                           inv_found;
   logic [WAY_W-1:0]               inv_way;
   logic [AGE_W-1:0]               inv_age;
   logic [WAY_W-1:0]               lru_way;
   logic [AGE_W-1:0]               lru_age;
   logic [WAY_W-1:0]               victim;
   logic [WAY_W-1:0]               chosen;
   logic [AGE_W-1:0]               old_age;
   logic [PAGE_W-1:0]              page_sel;
   logic [WIDE_W-1:0]              phys_wide;
   logic [NUM_WAYS-1:0]            clear_mask;

   logic [CNT_W-1:0]  access_ff, access_in;
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [PHYS_W-1:0] phys_ff;
   logic              hit_ff;

   // Page offset field, clamped to the supported range.
   always_comb begin
      if (offset_bits_ff < OFFSET_MIN) begin
         eff_off = OFFSET_MIN;
      end else if (offset_bits_ff > OFFSET_MAX) begin
         eff_off = OFFSET_MAX;
      end else begin
         eff_off = offset_bits_ff;
      end
   end

   // Split the incoming address; the tag is every bit above the index.
   always_comb begin
      vaddr      = ADDR_WIDTH'(req_virt_addr);
      tag_shift  = SHIFT_W'(eff_off) + SHIFT_W'(IDX_BITS);
      req_offset = vaddr & ~({ADDR_WIDTH{1'b1}} << eff_off);
      req_set    = SET_W'((vaddr >> eff_off) & IDX_MASK);
      if (tag_shift >= SHIFT_W'(ADDR_WIDTH)) begin
         req_tag = '0;
      end else begin
         req_tag = TAG_W'(vaddr >> tag_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_bits_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff         <= req_set;
         tag_ff         <= req_tag;
         offset_ff      <= req_offset;
         walk_page_ff   <= req_walk_page;
         target_page_ff <= req_target_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         walk_cnt_ff <= '0;
      end else if (cmd.inv_clear) begin
         walk_cnt_ff <= walk_cnt_ff + SET_W'(1);
      end
   end

   assign status.walk_last = (walk_cnt_ff == SET_W'(SET_COUNT - 1));

   // One row holds all ways of a set; rows are read whole and written whole.
   assign rd_addr = cmd.capture ? req_set : walk_cnt_ff;
   assign rd_en   = cmd.capture || cmd.inv_read;
   assign wr_en   = cmd.xlate_done && !hit_any;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[set_ff]  <= tag_row_in;
         page_mem[set_ff] <= page_row_in;
      end
      if (rd_en) begin
         tag_row_ff  <= tag_mem[rd_addr];
         page_row_ff <= page_mem[rd_addr];
      end
   end

   // Lookup in the captured set.
   always_comb begin
      cur_valid = valid_ff[set_ff];
      cur_age   = age_ff[set_ff];

      hit_any = 1'b0;
      hit_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (cur_valid[w] && (tag_row_ff[w] == tag_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      // Among invalid ways the oldest is preferred; otherwise the LRU way.
      inv_found = 1'b0;
      inv_way   = '0;
      inv_age   = '0;
      lru_way   = '0;
      lru_age   = cur_age[0];
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!cur_valid[w] && (!inv_found || (cur_age[w] > inv_age))) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
            inv_age   = cur_age[w];
         end
         if (cur_age[w] > lru_age) begin
            lru_way = WAY_W'(w);
            lru_age = cur_age[w];
         end
      end
      victim = inv_found ? inv_way : lru_way;
      chosen = hit_any ? hit_way : victim;
      old_age = cur_age[chosen];

      page_sel  = hit_any ? page_row_ff[hit_way] : walk_page_ff;
      phys_wide = (WIDE_W'(page_sel) << eff_off) | WIDE_W'(offset_ff);

      tag_row_in          = tag_row_ff;
      page_row_in         = page_row_ff;
      tag_row_in[victim]  = tag_ff;
      page_row_in[victim] = walk_page_ff;

      for (int w = 0; w < NUM_WAYS; w++) begin
         clear_mask[w] = (page_row_ff[w] == target_page_ff);
      end
   end

   // Next state of the valid and age flops and of the counters.
   always_comb begin
      valid_in   = valid_ff;
      age_in     = age_ff;
      access_in  = access_ff;
      hit_cnt_in = hit_cnt_ff;
      if (cmd.xlate_done) begin
         valid_in[set_ff][chosen] = 1'b1;
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (cur_age[w] < old_age) begin
               age_in[set_ff][w] = cur_age[w] + AGE_W'(1);
            end
         end
         age_in[set_ff][chosen] = '0;
         access_in  = access_ff + CNT_W'(1);
         hit_cnt_in = hit_cnt_ff + CNT_W'(hit_any);
      end
      if (cmd.inv_clear) begin
         valid_in[walk_cnt_ff] = valid_ff[walk_cnt_ff] & ~clear_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         access_ff  <= '0;
         hit_cnt_ff <= '0;
         for (int s = 0; s < SET_COUNT; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               age_ff[s][w] <= AGE_W'(w);
            end
         end
      end else begin
         valid_ff   <= valid_in;
         age_ff     <= age_in;
         access_ff  <= access_in;
         hit_cnt_ff <= hit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.xlate_done) begin
         phys_ff <= PHYS_W'(ADDR_WIDTH'(phys_wide));
         hit_ff  <= hit_any;
      end else if (cmd.inv_done) begin
         phys_ff <= '0;
         hit_ff  <= 1'b0;
      end
   end

   // The counters move only when a new result is loaded, so they serve
   // directly as the result fields.
   assign rsp_phys_addr    = phys_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_access_total = access_ff;
   assign rsp_hit_total    = hit_cnt_ff;

endmodule

FILE: rtl/set_assoc_tlb_lru.sv
// Set-associative TLB with true LRU replacement: top level.
//
// Requests arrive on the req_ channel and results leave on the rsp_ channel;
// a transfer takes place at a rising edge with valid high and stall low.
// Each request gives exactly one result, in request order.
// Translate (req_mode 0): the set is read in the transfer cycle, the next
// cycle in which the output register is free compares all ways, updates
// LRU ages and loads the result register, which raises rsp_valid.
// Invalidate (req_mode 1): the sets are swept in order, each read and then
// cleared; the result is loaded once the output register is free.
// Only one request is worked on at a time; req_stall is high while it is.
// A request may be transferred while the previous result still waits.
// If rsp_stall holds the output, a finished request waits in the block
// and the result register keeps its value.
// csr_wr_en writes offset_bits; write it only while the block is idle.
// Reset (synchronous, active high) clears all valid bits, the counters and
// rsp_valid, sets the per-set ages to way order and offset_bits to 12.
module set_assoc_tlb_lru import stlb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [OFFCFG_W-1:0] csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [VADDR_W-1:0]  req_virt_addr,
   input  logic [PAGE_W-1:0]   req_walk_page,
   input  logic [PAGE_W-1:0]   req_target_page,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PHYS_W-1:0]   rsp_phys_addr,
   output logic                rsp_hit,
   output logic [CNT_W-1:0]    rsp_access_total,
   output logic [CNT_W-1:0]    rsp_hit_total
);

   stlb_cmd_type    cmd;
   stlb_status_type status;

   stlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   stlb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_virt_addr    (req_virt_addr),
      .req_walk_page    (req_walk_page),
      .req_target_page  (req_target_page),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_hit          (rsp_hit),
      .rsp_access_total (rsp_access_total),
      .rsp_hit_total    (rsp_hit_total)
   );

endmodule

FILE: rtl/stlb_checker.sv
// Port-level checker of the TLB and its bind to the top level.
`include "set_assoc_tlb_lru_defines.svh"

module stlb_checker import stlb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [PHYS_W-1:0] rsp_phys_addr,
   input logic              rsp_hit,
   input logic [CNT_W-1:0]  rsp_access_total,
   input logic [CNT_W-1:0]  rsp_hit_total
);

   // A held result keeps its payload.
   `STLB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_phys_addr) && $stable(rsp_hit) && $stable(rsp_access_total) && $stable(rsp_hit_total))

   // One request at a time: after a transfer the block is busy.
   `STLB_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // A result appears only out of a busy cycle.
   `STLB_ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))

   // Every hit is also counted as an access.
   `STLB_ASSERT_IMP(a_hit_counts_access, !$stable(rsp_hit_total), !$stable(rsp_access_total))

endmodule

bind set_assoc_tlb_lru stlb_checker u_stlb_checker (.*);
